>>> rtl/core/uart_rx_queue_xon_xoff_unit_defines.svh
// Assertion macros used by the receive queue controller RTL.
`ifndef UART_RX_QUEUE_XON_XOFF_UNIT_DEFINES_SVH
`define UART_RX_QUEUE_XON_XOFF_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URXQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("urxq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define URXQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("urxq: next-cycle check failed");

`endif

>>> rtl/core/urxq_pkg.sv
// Types, codes and constants of the UART receive queue with XON/XOFF flow control.
package urxq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int BYTE_W          = 8;
	localparam int FILL_W          = 8;
	localparam int CFG_IDX_W       = 8;

	// Flow control characters.
	localparam logic [BYTE_W-1:0] CODE_XON  = 8'h11;
	localparam logic [BYTE_W-1:0] CODE_XOFF = 8'h13;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LEVEL = 8'd1;
	localparam logic                 FLOW_ENABLE_RST = 1'b1;
	localparam logic [BYTE_W-1:0]    PAUSE_LEVEL_RST = 8'd42;

	// Item actions.
	localparam logic [1:0] ACT_RECEIVE = 2'd0;
	localparam logic [1:0] ACT_TAKE    = 2'd1;
	localparam logic [1:0] ACT_PEEK    = 2'd2;
	localparam logic [1:0] ACT_FLUSH   = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_error;
	} urxq_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_valid;
		logic [BYTE_W-1:0] tx_ctrl;
		logic              tx_ctrl_valid;
		logic              host_paused;
		logic [FILL_W-1:0] fill_level;
		logic              overflow;
	} urxq_out_t;

endpackage

>>> rtl/core/urxq_mem.sv
// Byte store of the receive queue: one write port, one registered read port.
module urxq_mem
	import urxq_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/urxq_ctrl.sv
// Queue pointers, flow control state, configuration registers and the first result stage.
module urxq_ctrl
	import urxq_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  urxq_in_t             in_data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 s1_move,
	output logic                 s1_vld,
	output urxq_out_t            s1_rslt,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [BYTE_W-1:0]    wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr
);

	`include "uart_rx_queue_xon_xoff_unit_defines.svh"

	localparam int            CMP_W    = (CW > BYTE_W) ? CW : BYTE_W;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic              flow_q;
	logic [BYTE_W-1:0] pause_q;
	logic [AW-1:0]     rd_ptr_q, wr_ptr_q, rd_ptr_n, wr_ptr_n;
	logic [CW-1:0]     cnt_q, cnt_n;
	logic              xoff_q, xoff_n;
	logic              paused_q, paused_n;
	logic              s1_vld_q;
	urxq_out_t         s1_q, rslt_n;
	logic              acc;

	// A new word enters when the first stage is empty or moving on.
	assign in_stall = s1_vld_q & ~s1_move;
	assign acc      = in_valid & ~in_stall;

	// Configuration registers; the port is always ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q  <= FLOW_ENABLE_RST;
			pause_q <= PAUSE_LEVEL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FLOW_ENABLE: flow_q  <= cfg_data[0];
				CFG_PAUSE_LEVEL: pause_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state and result of one item.
	always_comb begin
		rd_ptr_n = rd_ptr_q;
		wr_ptr_n = wr_ptr_q;
		cnt_n    = cnt_q;
		xoff_n   = xoff_q;
		paused_n = paused_q;
		rslt_n   = '0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;

		// With flow control off, an outstanding XOFF is released at once.
		if (!flow_q && xoff_q) begin
			rslt_n.tx_ctrl       = CODE_XON;
			rslt_n.tx_ctrl_valid = 1'b1;
			xoff_n               = 1'b0;
		end

		case (in_data.action)
			ACT_RECEIVE: begin
				if (!in_data.rx_error) begin
					if (flow_q && in_data.rx_byte == CODE_XOFF) begin
						paused_n = 1'b1;
					end else if (flow_q && in_data.rx_byte == CODE_XON) begin
						paused_n = 1'b0;
					end else begin
						if (cnt_q == FULL_CNT) begin
							rslt_n.overflow = 1'b1;
						end else begin
							wr_en    = 1'b1;
							wr_ptr_n = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
							cnt_n    = cnt_q + CW'(1);
						end
						if (flow_q && CMP_W'(cnt_n) > CMP_W'(pause_q)) begin
							rslt_n.tx_ctrl       = CODE_XOFF;
							rslt_n.tx_ctrl_valid = 1'b1;
							xoff_n               = 1'b1;
						end
					end
				end
			end
			ACT_TAKE: begin
				if (cnt_q != '0) begin
					rd_en            = 1'b1;
					rslt_n.out_valid = 1'b1;
					rd_ptr_n         = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
					cnt_n            = cnt_q - CW'(1);
				end else if (flow_q && xoff_q) begin
					rslt_n.tx_ctrl       = CODE_XON;
					rslt_n.tx_ctrl_valid = 1'b1;
					xoff_n               = 1'b0;
				end
			end
			ACT_PEEK: begin
				if (cnt_q != '0) begin
					rd_en            = 1'b1;
					rslt_n.out_valid = 1'b1;
				end
			end
			default: begin
				rd_ptr_n = '0;
				wr_ptr_n = '0;
				cnt_n    = '0;
			end
		endcase

		rslt_n.host_paused = paused_n;
		rslt_n.fill_level  = FILL_W'(cnt_n);

		// Memory accesses only happen for an accepted word.
		wr_en = wr_en & acc;
		rd_en = rd_en & acc;
	end

	assign wr_addr = wr_ptr_q;
	assign wr_data = in_data.rx_byte;
	assign rd_addr = rd_ptr_q;

	// Queue and flow control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			xoff_q   <= 1'b0;
			paused_q <= 1'b0;
		end else if (acc) begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			cnt_q    <= cnt_n;
			xoff_q   <= xoff_n;
			paused_q <= paused_n;
		end
	end

	// First result stage; the read data, registered in the store alongside it, joins it ahead of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_move) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_q <= rslt_n;
		end
	end

	assign s1_vld  = s1_vld_q;
	assign s1_rslt = s1_q;

	`URXQ_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL_CNT)
	`URXQ_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, cnt_q == '0, wr_ptr_q == rd_ptr_q)
	`URXQ_ASSERT_IMPL(a_xoff_noted, clk, arst_n,
		s1_vld_q && s1_q.tx_ctrl_valid && s1_q.tx_ctrl == CODE_XOFF, xoff_q)
	`URXQ_ASSERT_IMPL(a_ovf_full, clk, arst_n, s1_vld_q && s1_q.overflow, cnt_q == FULL_CNT)
	`URXQ_ASSERT_NEXT(a_flush_empty, clk, arst_n, acc && in_data.action == ACT_FLUSH,
		cnt_q == '0 && rd_ptr_q == '0)

endmodule

>>> rtl/core/uart_rx_queue_xon_xoff_unit.sv
// A result word passes through the first result stage and then the output register after its item word is accepted.
// One item is taken per cycle while the output side does not stall.
// The queue store is a one-port-write, one-port-read memory with a registered read port.
// Reset clears the pointers, fill count and flow control flags and loads the register defaults.
// The store itself is not cleared and needs no clearing pass; items are taken at once.
module uart_rx_queue_xon_xoff_unit
	import urxq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  urxq_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output urxq_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic              s1_move, s1_vld;
	urxq_out_t         s1_rslt, rslt_d;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [BYTE_W-1:0] wr_data, rd_data;
	logic              out_vld_q;
	urxq_out_t         out_q;

	assign cfg_ready = 1'b1;

	urxq_ctrl #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s1_move   (s1_move),
		.s1_vld    (s1_vld),
		.s1_rslt   (s1_rslt),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	urxq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Merge the read data into the result; no byte when nothing was read.
	always_comb begin
		rslt_d          = s1_rslt;
		rslt_d.out_byte = s1_rslt.out_valid ? rd_data : '0;
	end

	// Output register; it takes a new word when empty or being drained.
	assign s1_move = ~out_vld_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= s1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_vld) begin
			out_q <= rslt_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule
